// ===== src/u2u8_pkg.sv =====
// Shared types, constants and byte encoder for the UTF-16 to UTF-8 transcoder.
package u2u8_pkg;

  localparam logic [15:0] HIGH_FIRST   = 16'hd800;
  localparam logic [15:0] HIGH_LAST    = 16'hdbff;
  localparam logic [15:0] LOW_FIRST    = 16'hdc00;
  localparam logic [15:0] LOW_LAST     = 16'hdfff;
  localparam logic [20:0] REPLACEMENT  = 21'h00fffd;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;
  localparam logic [15:0] ONE_BYTE_MAX = 16'h007f;
  localparam logic [15:0] TWO_BYTE_MAX = 16'h07ff;
  localparam logic [2:0]  REPL_LEN     = 3'd3;
  localparam logic [7:0]  TERM_BYTE    = 8'h00;

  // One queued unit of work: optional U+FFFD flush, at most one code point, optional terminator.
  typedef struct packed {
    logic        fffd_first;
    logic [20:0] cp;
    logic [2:0]  cp_len;   // 0 when no code point
    logic        term;
  } job_t;

  // Byte idx of the UTF-8 encoding of cp, which takes len bytes.
  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [2:0] len,
                                          input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (len)
      3'd1: b = {1'b0, cp[6:0]};
      3'd2: begin
        if (idx == 3'd0) b = {3'b110, cp[10:6]};
        else             b = {2'b10, cp[5:0]};
      end
      3'd3: begin
        unique case (idx)
          3'd0:    b = {4'b1110, cp[15:12]};
          3'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          3'd0:    b = {5'b11110, cp[20:18]};
          3'd1:    b = {2'b10, cp[17:12]};
          3'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// ===== src/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder.
// One UTF-16 code unit enters per item and its UTF-8 bytes leave one per cycle while
// out_ready is high. An item makes 1 byte for ASCII other than NUL, 2 or 3 for other
// BMP units, 4 for a surrogate pair, plus 3 when a held high surrogate is flushed
// as U+FFFD and 1 for an appended terminator (up to 7). A high surrogate that is held
// makes no byte. The byte serializer sets the rate; a job queue of QUEUE_DEPTH entries
// lets input keep flowing while it is busy.
module utf16_to_utf8_transcoder import u2u8_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        string_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        is_terminator
);

  logic       append_terminator;
  logic       q_not_full, push, pop, head_valid;
  job_t       push_job, head;
  logic [2:0] byte_idx;

  always_ff @(posedge clk) begin
    if (rst)            append_terminator <= 1'b1;
    else if (cfg_wr_en) append_terminator <= cfg_wr_data;
  end

  u2u8_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .code_unit         (code_unit),
    .string_end        (string_end),
    .append_terminator (append_terminator),
    .q_ready           (q_not_full),
    .push              (push),
    .job               (push_job)
  );

  u2u8_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .not_full   (q_not_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  u2u8_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .is_terminator (is_terminator),
    .byte_idx      (byte_idx)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> q_not_full) else $error("job queue overflow");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("pop from empty job queue");

  a_term_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_terminator |-> last_of_run && out_byte == TERM_BYTE)
    else $error("terminator byte not last or not zero");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    byte_idx <= 3'd6) else $error("byte index past longest run");

endmodule

// ===== src/u2u8_front.sv =====
// Front end: takes code units, tracks a held high surrogate, builds jobs.
module u2u8_front import u2u8_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        string_end,
  input  logic        append_terminator,
  input  logic        q_ready,
  output logic        push,
  output job_t        job
);

  logic       high_pending, high_pending_next;
  logic [9:0] high_bits, high_bits_next;
  logic       accept, is_high, is_low;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign is_high  = (code_unit >= HIGH_FIRST) && (code_unit <= HIGH_LAST);
  assign is_low   = (code_unit >= LOW_FIRST) && (code_unit <= LOW_LAST);

  always_comb begin
    job               = '0;
    high_pending_next = 1'b0;
    high_bits_next    = '0;
    if (high_pending && is_low) begin
      job.cp     = SUPP_BASE + {1'b0, high_bits, code_unit[9:0]};
      job.cp_len = 3'd4;
    end else begin
      // a held high surrogate that is not paired is flushed first
      job.fffd_first = high_pending;
      if (is_high) begin
        if (string_end) begin
          job.cp     = REPLACEMENT;
          job.cp_len = REPL_LEN;
        end else begin
          high_pending_next = 1'b1;
          high_bits_next    = code_unit[9:0];
        end
      end else if (is_low || code_unit == 16'h0000) begin
        job.cp     = REPLACEMENT;
        job.cp_len = REPL_LEN;
      end else begin
        job.cp = {5'b0, code_unit};
        if (code_unit <= ONE_BYTE_MAX)      job.cp_len = 3'd1;
        else if (code_unit <= TWO_BYTE_MAX) job.cp_len = 3'd2;
        else                                job.cp_len = 3'd3;
      end
    end
    job.term = string_end && append_terminator;
  end

  assign push = accept && (job.fffd_first || job.cp_len != 3'd0 || job.term);

  always_ff @(posedge clk) begin
    if (rst) begin
      high_pending <= 1'b0;
      high_bits    <= '0;
    end else if (accept) begin
      high_pending <= high_pending_next;
      high_bits    <= high_bits_next;
    end
  end

endmodule

// ===== src/u2u8_queue.sv =====
// Small job queue between the front end and the byte serializer.
module u2u8_queue import u2u8_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic not_full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign not_full   = (count != CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== src/u2u8_back.sv =====
// Back end: walks each job one byte per cycle, while out_ready allows, into the output register.
module u2u8_back import u2u8_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  job_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       is_terminator,
  output logic [2:0] byte_idx
);

  logic [2:0] nf, total, j;
  logic       load, last, term_sel;
  logic [7:0] byte_sel;

  assign nf    = head.fffd_first ? REPL_LEN : 3'd0;
  assign total = nf + head.cp_len + {2'b0, head.term};
  assign j     = byte_idx - nf;
  assign last  = (byte_idx == total - 3'd1);
  assign load  = head_valid && (!out_valid || out_ready);
  assign pop   = load && last;

  always_comb begin
    term_sel = 1'b0;
    if (byte_idx < nf) begin
      byte_sel = enc_byte(REPLACEMENT, REPL_LEN, byte_idx);
    end else if (j < head.cp_len) begin
      byte_sel = enc_byte(head.cp, head.cp_len, j);
    end else begin
      byte_sel = TERM_BYTE;
      term_sel = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_idx  <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      byte_idx  <= last ? 3'd0 : byte_idx + 3'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= byte_sel;
      last_of_run   <= last;
      is_terminator <= term_sel;
    end
  end

endmodule

// ===== sim/utf8_stream_checker.sv =====
// Watches the transcoder channels, predicts the UTF-8 byte stream and compares it.
module utf8_stream_checker import u2u8_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        string_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        last_of_run,
  input  logic        is_terminator,
  output int          failures,
  output int          bytes_owed
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       term;
  } utf8_byte_t;

  utf8_byte_t bytes_due[$];
  logic       term_enable;
  logic       hold_high;
  logic [9:0] held_bits;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
    failures++;
  endtask

  function automatic void push_byte(input logic [7:0] b, input logic t);
    bytes_due.push_back('{value: b, last: 1'b0, term: t});
  endfunction

  function automatic void push_codepoint(input logic [20:0] cp);
    if (cp <= 21'h7f) begin
      push_byte(cp[7:0], 1'b0);
    end else if (cp <= 21'h7ff) begin
      push_byte(8'hc0 | 8'(cp[10:6]), 1'b0);
      push_byte(8'h80 | 8'(cp[5:0]), 1'b0);
    end else if (cp <= 21'hffff) begin
      push_byte(8'he0 | 8'(cp[15:12]), 1'b0);
      push_byte(8'h80 | 8'(cp[11:6]), 1'b0);
      push_byte(8'h80 | 8'(cp[5:0]), 1'b0);
    end else begin
      push_byte(8'hf0 | 8'(cp[20:18]), 1'b0);
      push_byte(8'h80 | 8'(cp[17:12]), 1'b0);
      push_byte(8'h80 | 8'(cp[11:6]), 1'b0);
      push_byte(8'h80 | 8'(cp[5:0]), 1'b0);
    end
  endfunction

  // Appends the bytes that one accepted code unit produces.
  function automatic void transcode_unit(input logic [15:0] unit, input logic at_end);
    int   first;
    logic paired;
    logic is_high;
    logic is_low;
    first   = bytes_due.size();
    paired  = 1'b0;
    is_high = unit >= HIGH_FIRST && unit <= HIGH_LAST;
    is_low  = unit >= LOW_FIRST && unit <= LOW_LAST;
    if (hold_high) begin
      if (is_low) begin
        push_codepoint(SUPP_BASE + 21'({held_bits, unit[9:0]}));
        paired = 1'b1;
      end else begin
        // held high surrogate with no partner is flushed first
        push_codepoint(REPLACEMENT);
      end
      hold_high = 1'b0;
      held_bits = '0;
    end
    if (!paired) begin
      if (is_high) begin
        if (at_end) begin
          push_codepoint(REPLACEMENT);
        end else begin
          hold_high = 1'b1;
          held_bits = unit[9:0];
        end
      end else if (is_low || unit == 16'h0000) begin
        push_codepoint(REPLACEMENT);
      end else begin
        push_codepoint(21'(unit));
      end
    end
    if (at_end && term_enable) push_byte(TERM_BYTE, 1'b1);
    if (bytes_due.size() > first) bytes_due[bytes_due.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    utf8_byte_t want;
    if (rst) begin
      bytes_due.delete();
      term_enable = 1'b1;
      hold_high   = 1'b0;
      held_bits   = '0;
      failures    = 0;
    end else begin
      if (in_valid && in_ready) transcode_unit(code_unit, string_end);
      if (cfg_wr_en) term_enable = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (bytes_due.size() == 0) begin
          report_mismatch("byte with none due", out_byte, 8'h00);
        end else begin
          want = bytes_due.pop_front();
          if (out_byte !== want.value) report_mismatch("out_byte", out_byte, want.value);
          if (last_of_run !== want.last)
            report_mismatch("last_of_run", 8'(last_of_run), 8'(want.last));
          if (is_terminator !== want.term)
            report_mismatch("is_terminator", 8'(is_terminator), 8'(want.term));
        end
      end
    end
    bytes_owed = bytes_due.size();
  end

endmodule

// ===== sim/utf16_to_utf8_transcoder_tb.sv =====
// Testbench top for the UTF-16 to UTF-8 transcoder: stimulus, watchdog and verdict.
module utf16_to_utf8_transcoder_tb;
  import u2u8_pkg::*;

  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 100;

  // {string_end, code_unit}
  localparam logic [16:0] DIRECTED_UNITS [24] = '{
    {1'b0, 16'h0041}, {1'b0, 16'h0000}, {1'b0, 16'h007f}, {1'b0, 16'h0080},
    {1'b0, 16'h07ff}, {1'b0, 16'h0800}, {1'b1, 16'hffff},
    {1'b0, 16'hd800}, {1'b1, 16'hdc00},
    {1'b0, 16'hdbff}, {1'b1, 16'hdfff},
    {1'b0, 16'hd83d}, {1'b0, 16'h0041},
    {1'b0, 16'hdabc}, {1'b0, 16'hdabd}, {1'b1, 16'hd801},
    {1'b0, 16'hdc00}, {1'b1, 16'hdfff},
    {1'b1, 16'h0001},
    {1'b0, 16'hd800}, {1'b1, 16'h0000},
    {1'b0, 16'hfffe}, {1'b1, 16'he000},
    {1'b1, 16'hd800}
  };

  logic        clk;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid    = 1'b0;
  logic [15:0] code_unit   = '0;
  logic        string_end  = 1'b0;
  logic        out_ready   = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic        is_terminator;
  int          failures;
  int          bytes_owed;
  bit          idle_on     = 1'b1;
  bit          stall_on    = 1'b1;
  int          items_sent  = 0;

  utf16_to_utf8_transcoder DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .code_unit    (code_unit),
    .string_end   (string_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .is_terminator(is_terminator)
  );

  utf8_stream_checker stream_chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .code_unit    (code_unit),
    .string_end   (string_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .is_terminator(is_terminator),
    .failures     (failures),
    .bytes_owed   (bytes_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver stalls in bursts of random length while stall_on is set.
  initial begin
    int stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) stall_left--;
      else if (stall_on && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
      out_ready <= (stall_left == 0);
    end
  end

  initial begin
    int quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
    $display("** utf16_to_utf8_transcoder: FAILED **");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_unit(input logic [15:0] unit, input logic fin);
    if (idle_on && $urandom_range(0, 49) == 0) begin
      // hold off until the output side has caught up completely
      in_valid <= 1'b0;
      do @(negedge clk); while (bytes_owed != 0);
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    code_unit  <= unit;
    string_end <= fin;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (bytes_owed != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_terminator(input logic enable);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= enable;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly valid text with surrogate pairs; some lone surrogates, NULs and raw noise.
  task automatic send_random_string();
    logic [15:0] units[$];
    int          len;
    len = $urandom_range(1, 6);
    while (units.size() < len) begin
      case ($urandom_range(0, 9))
        0, 1: units.push_back(16'($urandom_range(1, 16'h7f)));
        2: units.push_back(16'($urandom_range(16'h80, 16'h7ff)));
        3, 4: begin
          if ($urandom_range(0, 1) == 0) units.push_back(16'($urandom_range(16'h800, 16'hd7ff)));
          else units.push_back(16'($urandom_range(16'he000, 16'hffff)));
        end
        5, 6, 7: begin
          units.push_back(16'($urandom_range(HIGH_FIRST, HIGH_LAST)));
          units.push_back(16'($urandom_range(LOW_FIRST, LOW_LAST)));
        end
        8: units.push_back(16'($urandom()));
        default: begin
          if ($urandom_range(0, 2) == 0) units.push_back(16'h0000);
          else units.push_back(16'($urandom_range(HIGH_FIRST, LOW_LAST)));
        end
      endcase
    end
    foreach (units[i]) send_unit(units[i], i == units.size() - 1);
  endtask

  task automatic random_phase(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) send_random_string();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_UNITS[i]) send_unit(DIRECTED_UNITS[i][15:0], DIRECTED_UNITS[i][16]);
    drain();

    set_terminator(1'b0);
    random_phase(PHASE_ITEMS);
    drain();

    set_terminator(1'b1);
    random_phase(PHASE_ITEMS);
    drain();

    // last stretch runs at full rate on both sides
    idle_on  = 1'b0;
    stall_on = 1'b0;
    set_terminator(1'b0);
    random_phase(PHASE_ITEMS);
    drain();

    if (failures == 0) $display("** utf16_to_utf8_transcoder: PASSED **");
    else $display("** utf16_to_utf8_transcoder: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/u2u8_pkg.sv
src/u2u8_front.sv
src/u2u8_queue.sv
src/u2u8_back.sv
src/utf16_to_utf8_transcoder.sv
sim/utf8_stream_checker.sv
sim/utf16_to_utf8_transcoder_tb.sv
